// File: design/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// implication checked with the consequent in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: design/sha_pkg.sv
// package: sha-256 constants and round functions
`default_nettype none
package sha_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned HASH_WORDS = 8;
    localparam int unsigned LEN_BITS = 61;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic t_word ror(input t_word v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

endpackage
`default_nettype wire

// File: design/sha_round.sv
// sha-256 round datapath: schedule memory, one round per cycle
`default_nettype none
module sha_round (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire sha_pkg::t_word i_hash [8],
    input  wire sha_pkg::t_word i_msg_word,
    output logic [3:0]       o_word_sel,
    output logic             o_done,
    output sha_pkg::t_word   o_hash [8]
);
    import sha_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD} t_state;

    t_word  r_win [16];
    t_state r_state;
    logic [5:0] r_t;
    t_word r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    t_word r_w1, r_w9, r_w14, r_w16;
    t_word w, t1, t2, s0, s1;

    // message word wanted in the next cycle
    assign o_word_sel = (r_state == S_RUN) ? 4'(r_t + 6'd1) : 4'd0;

    always_comb begin
        s0 = ror(r_w1, 7) ^ ror(r_w1, 18) ^ (r_w1 >> 3);
        s1 = ror(r_w14, 17) ^ ror(r_w14, 19) ^ (r_w14 >> 10);
        w  = (r_t < 6'd16) ? i_msg_word : (r_w16 + s0 + r_w9 + s1);
        t1 = r_h + (ror(r_e, 6) ^ ror(r_e, 11) ^ ror(r_e, 25)) +
             ((r_e & r_f) ^ (~r_e & r_g)) + round_k(r_t) + w;
        t2 = (ror(r_a, 2) ^ ror(r_a, 13) ^ ror(r_a, 22)) +
             ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    // schedule window read at fixed offsets from the round counter
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            r_win[r_t[3:0]] <= w;
        end
        r_w1  <= r_win[4'(r_t + 6'd2)];
        r_w9  <= r_win[4'(r_t + 6'd10)];
        r_w14 <= r_win[4'(r_t + 6'd15)];
        r_w16 <= r_win[4'(r_t + 6'd1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RUN;
                        r_t <= '0;
                        {r_a, r_b, r_c, r_d} <= {i_hash[0], i_hash[1], i_hash[2], i_hash[3]};
                        {r_e, r_f, r_g, r_h} <= {i_hash[4], i_hash[5], i_hash[6], i_hash[7]};
                    end
                end
                S_RUN: begin
                    r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    o_hash[0] <= i_hash[0] + r_a; o_hash[1] <= i_hash[1] + r_b;
                    o_hash[2] <= i_hash[2] + r_c; o_hash[3] <= i_hash[3] + r_d;
                    o_hash[4] <= i_hash[4] + r_e; o_hash[5] <= i_hash[5] + r_f;
                    o_hash[6] <= i_hash[6] + r_g; o_hash[7] <= i_hash[7] + r_h;
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                    r_t <= '0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/sha256_stream_hasher_core.sv
// top level: byte-stream sha-256 hasher
// input channel: one request per accepted cycle carries i_data_byte, i_byte_valid, i_last
// a request without a byte carries nothing but may end the message
// bytes go into a 16-word block memory; the 64th byte starts a 64-round compression
// and the input is then stalled until that compression is done
// throughput: one byte per cycle inside a block
// on last the 0x80 byte, zeros and the bit length are written one byte per cycle,
// into the rest of the block after the n buffered bytes, then one or two compressions follow
// a message over 2^61-1 bytes skips padding and gives eight zero words with
// o_length_error set, the cycle after last (after compression if the byte fills a block)
// eight digest words follow, word 0 first, one per cycle; a stalled word is held
// input stall stays high during compression, padding and digest output
// reset (synchronous) restores the initial hash and empties the block
`default_nettype none
module sha256_stream_hasher_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [7:0]   i_data_byte,
    input  wire         i_byte_valid,
    input  wire         i_last,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_length_error
);
    import sha_pkg::*;

    typedef enum logic [2:0] {S_FILL, S_COMP, S_PAD, S_OUT} t_state;

    t_word r_mem [16];
    t_state r_state;
    logic [5:0] r_fill;
    logic [60:0] r_len;
    logic r_ovf, r_final, r_more;
    t_word r_hash [8];
    logic [2:0] r_idx;
    logic r_start;
    logic [6:0] r_rdp;
    t_word r_word;
    logic [3:0] word_sel;
    logic done;
    t_word new_hash [8];
    logic acc;
    logic [63:0] bits;
    logic [7:0] pad_byte;

    assign o_stall = (r_state != S_FILL);
    assign acc = i_valid && !o_stall;
    assign bits = {r_len, 3'b000};

    assign pad_byte = (r_rdp[5:0] == r_fill && !r_more) ? PAD_BYTE :
                      (r_rdp[5:0] >= LEN_POS && r_final) ?
                          bits[{~r_rdp[2:0], 3'b000} +: 8] : 8'h00;

    sha_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_hash(r_hash),
        .i_msg_word(r_word), .o_word_sel(word_sel), .o_done(done), .o_hash(new_hash)
    );

    // block memory: byte writes, one registered word read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL && acc && i_byte_valid) begin
            r_mem[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_data_byte;
        end else if (r_state == S_PAD) begin
            r_mem[r_rdp[5:2]][{~r_rdp[1:0], 3'b000} +: 8] <= pad_byte;
        end
        r_word <= r_mem[word_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill <= '0;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_final <= 1'b0;
            r_more <= 1'b0;
            r_start <= 1'b0;
            r_idx <= '0;
            r_rdp <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < 8; i++) r_hash[i] <= init_hash(3'(i));
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_FILL: begin
                    if (acc) begin
                        if (i_byte_valid) begin
                            if (&r_len) r_ovf <= 1'b1;
                            else r_len <= r_len + 61'd1;
                            r_fill <= r_fill + 6'd1;
                        end
                        if (i_byte_valid && r_fill == 6'd63) begin
                            r_state <= S_COMP;
                            r_start <= 1'b1;
                            r_final <= 1'b0;
                            r_more <= i_last;
                        end else if (i_last) begin
                            r_more <= 1'b0;
                            if (r_ovf || (i_byte_valid && &r_len)) begin
                                r_state <= S_OUT;
                                r_idx <= '0;
                                o_valid <= 1'b1;
                            end else begin
                                r_state <= S_PAD;
                                r_rdp <= {1'b0, r_fill + 6'(i_byte_valid)};
                                r_final <= ((r_fill + 6'(i_byte_valid)) < LEN_POS);
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_rdp <= r_rdp + 7'd1;
                    if (r_rdp[5:0] == 6'd63) begin
                        r_state <= S_COMP;
                        r_start <= 1'b1;
                    end
                end
                S_COMP: begin
                    if (done) begin
                        r_hash <= new_hash;
                        r_fill <= '0;
                        if (r_final) begin
                            r_state <= S_OUT;
                            r_idx <= '0;
                            o_valid <= 1'b1;
                        end else if (r_more && r_ovf) begin
                            r_state <= S_OUT;
                            r_idx <= '0;
                            o_valid <= 1'b1;
                            r_more <= 1'b0;
                        end else if (r_more) begin
                            r_state <= S_PAD;
                            r_rdp <= '0;
                            r_fill <= '0;
                            r_final <= 1'b1;
                            r_more <= 1'b0;
                        end else if (r_fill != 6'd0 || r_rdp != 7'd0) begin
                            r_state <= S_PAD;
                            r_rdp <= '0;
                            r_final <= 1'b1;
                            r_more <= 1'b1;
                        end else begin
                            r_state <= S_FILL;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            o_valid <= 1'b0;
                            r_state <= S_FILL;
                            r_fill <= '0;
                            r_len <= '0;
                            r_ovf <= 1'b0;
                            r_rdp <= '0;
                            for (int i = 0; i < 8; i++) r_hash[i] <= init_hash(3'(i));
                        end
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    assign o_digest_word = r_ovf ? 32'h0 : r_hash[r_idx];
    assign o_word_index = r_idx;
    assign o_last_word = (r_idx == 3'd7);
    assign o_length_error = r_ovf;
endmodule
`default_nettype wire

// File: design/sha_checker.sv
// port checker for the hasher, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sha_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_stall,
    input wire [2:0]  o_word_index,
    input wire        o_last_word,
    input wire        o_length_error
);
    `CHK_IMPLY(a_last_idx, i_clk, i_rst_n, o_valid, (o_last_word == (o_word_index == 3'd7)))
    `CHK_IMPLY(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    `CHK_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word,
              o_valid && o_word_index == $past(o_word_index) + 3'd1)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
              o_valid && $stable(o_word_index) && $stable(o_length_error))
endmodule
bind sha256_stream_hasher_core sha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_word_index(o_word_index), .o_last_word(o_last_word),
    .o_length_error(o_length_error)
);
`default_nettype wire
